// ===== rtl/core/mpsd_pkg.sv =====
// Shared types and constants for the minimum pairwise squared distance core.
package mpsd_pkg;

    localparam int unsigned START_MIN = 1000000;
    localparam int unsigned DIST_W = 20;
    localparam int unsigned CFG_DATA_W = 7;
    localparam int unsigned CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_POINT_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIMENSION_COUNT = 2'd1;

    typedef enum logic [1:0] {
        ST_LOAD   = 2'b01,
        ST_SEARCH = 2'b10
    } state_t;

    // Tag that travels with each dimension step through the distance pipeline.
    typedef struct packed {
        logic valid;
        logic last_dim;
        logic last_pair;
    } step_tag_t;

endpackage

// ===== rtl/core/min_pairwise_squared_distance_core.sv =====
// Minimum pairwise squared distance core: point loader, pair walk and running minimum.
//
// Usage:
//   Coordinates come in one request at a time on coordinate, taken at a clock edge
//   with start high and busy low, point-major and then in dimension order.
//   point_count and dimension_count are set on the write port (wr_en, wr_index,
//   wr_data), by the user only while the core is idle; the core does not enforce
//   this. A write to either register drops a partly loaded set; others are ignored.
//   Once the whole set is stored the core raises busy and walks every pair of
//   distinct points, one dimension per cycle, reading both coordinates from two
//   copies of the point memory. A pipeline of read, difference, square and
//   accumulate follows the walk; done and the final minimum are registered
//   together as the last dimension of the last pair is accumulated.
//   With fewer than two points the answer comes in the cycle after the last
//   coordinate is taken; with zero points every request answers that way.
//   The result is on min_distance for the single cycle that done is high; the
//   receiver cannot stall it. Distances saturate at 1000000.
//   Reset empties the loader, sets both registers to 2 and the minimum to
//   1000000. The point memory is not cleared; only entries of the current set
//   are ever used.
module min_pairwise_squared_distance_core #(
    parameter int unsigned MAX_POINTS = 64,
    parameter int unsigned MAX_DIMS   = 8,
    parameter int unsigned COORD_BITS = 10
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [COORD_BITS-1:0]               coordinate,
    output logic                                done,
    output logic [mpsd_pkg::DIST_W-1:0]         min_distance,
    input  logic                                wr_en,
    input  logic [mpsd_pkg::CFG_INDEX_W-1:0]    wr_index,
    input  logic [mpsd_pkg::CFG_DATA_W-1:0]     wr_data
);
    import mpsd_pkg::*;

    localparam int unsigned DEPTH  = MAX_POINTS * MAX_DIMS;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned PT_W   = $clog2(MAX_POINTS);
    localparam int unsigned PN_W   = $clog2(MAX_POINTS + 1);
    localparam int unsigned DIM_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int unsigned DN_W   = $clog2(MAX_DIMS + 1);
    localparam int unsigned PC_W   = (PN_W > 7) ? PN_W : 7;
    localparam int unsigned DC_W   = (DN_W > 4) ? DN_W : 4;
    localparam int unsigned SQ_W   = 2 * COORD_BITS;
    localparam int unsigned SUM_W  = SQ_W + DN_W;
    localparam int unsigned CMP_W  = (SUM_W > DIST_W) ? SUM_W : DIST_W;
    localparam logic [DIST_W-1:0] START_VAL = DIST_W'(START_MIN);

    logic [COORD_BITS-1:0] mem_a [DEPTH];
    logic [COORD_BITS-1:0] mem_b [DEPTH];

    logic [6:0]            point_count_reg;
    logic [3:0]            dimension_count_reg;
    state_t                state_reg, state_next;

    logic [PT_W-1:0]       ld_pt_reg, ld_pt_next;
    logic [DIM_W-1:0]      ld_d_reg, ld_d_next;
    logic [ADDR_W-1:0]     ld_addr_reg, ld_addr_next;

    logic                  issue_reg, issue_next;
    logic [PT_W-1:0]       pi_reg, pi_next;
    logic [PT_W-1:0]       pj_reg, pj_next;
    logic [DIM_W-1:0]      d_reg, d_next;
    logic [ADDR_W-1:0]     base_i_reg, base_i_next;
    logic [ADDR_W-1:0]     base_j_reg, base_j_next;

    step_tag_t             tag0;
    step_tag_t             tag1_reg, tag2_reg, tag3_reg;
    logic [COORD_BITS-1:0] rd_a_reg, rd_b_reg;
    logic [COORD_BITS-1:0] diff_reg;
    logic [SQ_W-1:0]       sq_reg;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [DIST_W-1:0]     best_reg, best_next;
    logic                  done_reg, done_next;

    logic [PN_W-1:0]       eff_pts, pts_m1, pts_m2;
    logic [DN_W-1:0]       eff_dims, dims_m1;
    logic [ADDR_W-1:0]     addr_a, addr_b;
    logic                  accept, load_last, cfg_hit;
    logic                  dim_last, pj_last, pi_last;
    logic [SUM_W-1:0]      acc_sum;

    // Clamp the configured counts to what the memory holds; a dimension count of zero counts as one.
    always_comb
    begin
        if (PC_W'(point_count_reg) > PC_W'(MAX_POINTS))
        begin
            eff_pts = PN_W'(MAX_POINTS);
        end
        else
        begin
            eff_pts = PN_W'(point_count_reg);
        end
        if (dimension_count_reg == 4'd0)
        begin
            eff_dims = DN_W'(1);
        end
        else if (DC_W'(dimension_count_reg) > DC_W'(MAX_DIMS))
        begin
            eff_dims = DN_W'(MAX_DIMS);
        end
        else
        begin
            eff_dims = DN_W'(dimension_count_reg);
        end
    end

    assign pts_m1  = eff_pts - PN_W'(1);
    assign pts_m2  = eff_pts - PN_W'(2);
    assign dims_m1 = eff_dims - DN_W'(1);

    assign accept    = start && !busy;
    assign load_last = (PN_W'(ld_pt_reg) == pts_m1) && (DN_W'(ld_d_reg) == dims_m1);
    assign cfg_hit   = wr_en && (wr_index == CFG_POINT_COUNT || wr_index == CFG_DIMENSION_COUNT);

    assign dim_last = DN_W'(d_reg) == dims_m1;
    assign pj_last  = PN_W'(pj_reg) == pts_m1;
    assign pi_last  = PN_W'(pi_reg) == pts_m2;

    assign addr_a = base_i_reg + ADDR_W'(d_reg);
    assign addr_b = base_j_reg + ADDR_W'(d_reg);

    assign tag0.valid     = issue_reg;
    assign tag0.last_dim  = dim_last;
    assign tag0.last_pair = dim_last && pj_last && pi_last;

    assign acc_sum = sum_reg + SUM_W'(sq_reg);

    always_comb
    begin
        state_next   = state_reg;
        ld_pt_next   = ld_pt_reg;
        ld_d_next    = ld_d_reg;
        ld_addr_next = ld_addr_reg;
        issue_next   = issue_reg;
        pi_next      = pi_reg;
        pj_next      = pj_reg;
        d_next       = d_reg;
        base_i_next  = base_i_reg;
        base_j_next  = base_j_reg;
        sum_next     = sum_reg;
        best_next    = best_reg;
        done_next    = 1'b0;

        case (state_reg)
            ST_LOAD:
            begin
                if (cfg_hit)
                begin
                    ld_pt_next   = '0;
                    ld_d_next    = '0;
                    ld_addr_next = '0;
                end
                else if (accept)
                begin
                    if (eff_pts == '0)
                    begin
                        best_next = START_VAL;
                        done_next = 1'b1;
                    end
                    else if (load_last)
                    begin
                        ld_pt_next   = '0;
                        ld_d_next    = '0;
                        ld_addr_next = '0;
                        best_next    = START_VAL;
                        if (eff_pts < PN_W'(2))
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            state_next  = ST_SEARCH;
                            issue_next  = 1'b1;
                            pi_next     = '0;
                            pj_next     = PT_W'(1);
                            d_next      = '0;
                            base_i_next = '0;
                            base_j_next = ADDR_W'(eff_dims);
                            sum_next    = '0;
                        end
                    end
                    else
                    begin
                        ld_addr_next = ld_addr_reg + ADDR_W'(1);
                        if (DN_W'(ld_d_reg) == dims_m1)
                        begin
                            ld_d_next  = '0;
                            ld_pt_next = ld_pt_reg + PT_W'(1);
                        end
                        else
                        begin
                            ld_d_next = ld_d_reg + DIM_W'(1);
                        end
                    end
                end
            end

            ST_SEARCH:
            begin
                // Pair walk: j runs past i, dimensions innermost.
                if (issue_reg)
                begin
                    if (!dim_last)
                    begin
                        d_next = d_reg + DIM_W'(1);
                    end
                    else
                    begin
                        d_next = '0;
                        if (!pj_last)
                        begin
                            pj_next     = pj_reg + PT_W'(1);
                            base_j_next = base_j_reg + ADDR_W'(eff_dims);
                        end
                        else if (!pi_last)
                        begin
                            pi_next     = pi_reg + PT_W'(1);
                            pj_next     = pi_reg + PT_W'(2);
                            base_i_next = base_i_reg + ADDR_W'(eff_dims);
                            base_j_next = base_i_reg + ADDR_W'({eff_dims, 1'b0});
                        end
                        else
                        begin
                            issue_next = 1'b0;
                        end
                    end
                end

                if (tag3_reg.valid)
                begin
                    if (tag3_reg.last_dim)
                    begin
                        sum_next = '0;
                        if (CMP_W'(acc_sum) < CMP_W'(best_reg))
                        begin
                            best_next = DIST_W'(acc_sum);
                        end
                    end
                    else
                    begin
                        sum_next = acc_sum;
                    end
                    if (tag3_reg.last_pair)
                    begin
                        state_next = ST_LOAD;
                        done_next  = 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = ST_LOAD;
                issue_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg     <= 7'd2;
            dimension_count_reg <= 4'd2;
            state_reg           <= ST_LOAD;
            ld_pt_reg           <= '0;
            ld_d_reg            <= '0;
            ld_addr_reg         <= '0;
            issue_reg           <= 1'b0;
            pi_reg              <= '0;
            pj_reg              <= '0;
            d_reg               <= '0;
            base_i_reg          <= '0;
            base_j_reg          <= '0;
            tag1_reg            <= '0;
            tag2_reg            <= '0;
            tag3_reg            <= '0;
            sum_reg             <= '0;
            best_reg            <= START_VAL;
            done_reg            <= 1'b0;
        end
        else
        begin
            if (wr_en && wr_index == CFG_POINT_COUNT)
            begin
                point_count_reg <= wr_data[6:0];
            end
            if (wr_en && wr_index == CFG_DIMENSION_COUNT)
            begin
                dimension_count_reg <= wr_data[3:0];
            end
            state_reg   <= state_next;
            ld_pt_reg   <= ld_pt_next;
            ld_d_reg    <= ld_d_next;
            ld_addr_reg <= ld_addr_next;
            issue_reg   <= issue_next;
            pi_reg      <= pi_next;
            pj_reg      <= pj_next;
            d_reg       <= d_next;
            base_i_reg  <= base_i_next;
            base_j_reg  <= base_j_next;
            tag1_reg    <= tag0;
            tag2_reg    <= tag1_reg;
            tag3_reg    <= tag2_reg;
            sum_reg     <= sum_next;
            best_reg    <= best_next;
            done_reg    <= done_next;
        end
    end

    // Two copies of the point store give both coordinates of a pair in the same cycle.
    // Nothing is written during the walk, so reads never meet a pending write.
    always_ff @(posedge clk)
    begin
        if (accept && !cfg_hit && eff_pts != '0)
        begin
            mem_a[ld_addr_reg] <= coordinate;
            mem_b[ld_addr_reg] <= coordinate;
        end
        rd_a_reg <= mem_a[addr_a];
        rd_b_reg <= mem_b[addr_b];
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= (rd_a_reg > rd_b_reg) ? (rd_a_reg - rd_b_reg) : (rd_b_reg - rd_a_reg);
        sq_reg   <= SQ_W'(diff_reg) * SQ_W'(diff_reg);
    end

    assign busy         = (state_reg != ST_LOAD);
    assign done         = done_reg;
    assign min_distance = best_reg;

endmodule
